// ----- rtl/core/swm_pkg.sv -----
package swm_pkg;

    localparam int DEF_MAX_WINDOW  = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    // Width and reset value of the window length register.
    localparam int            CFG_W     = 5;
    localparam logic [CFG_W-1:0] RESET_LEN = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_swm_state;

endpackage

// ----- rtl/core/swm_sample_if.sv -----
interface swm_sample_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ----- rtl/core/swm_median_if.sv -----
interface swm_median_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

// ----- rtl/core/sliding_window_median.sv -----
// Sliding-window median filter. Each accepted sample transaction overwrites the
// oldest slot of a ring of window_length samples (written through i_cfg_we and
// i_cfg_wdata; the user must write it only while the block is idle, which the
// block does not enforce; 0 acts as 1 and values above MAX_WINDOW act as
// MAX_WINDOW) and yields one median transaction: the element of rank
// floor(length/2) in ascending order, i.e. the upper median for even lengths.
// The ring resets to zeros, so the first results include those zeros. The
// median is found by bit-serial radix selection: every window slot is a
// rotating shift register, and each cycle one bit of all slots is examined,
// from the most significant down, narrowing the candidate set and producing
// one result bit. The sample is written at the accepting edge itself; the
// result bits are gathered in the selection state and copied into the result
// register in the hand-off state. The input is ready again right after the
// hand-off, so no new sample is taken before the previous one is through.
// The hand-off waits while an earlier median has not yet been taken by its
// consumer. The result sits in an output register, so a new sample is taken
// while the previous median still waits for its consumer.
module sliding_window_median #(
    parameter int MAX_WINDOW  = swm_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [swm_pkg::CFG_W-1:0] i_cfg_wdata,
    swm_sample_if.sink                i_smp,
    swm_median_if.source              o_med
);
    import swm_pkg::*;

    // Length values reach MAX_WINDOW; comparisons against the 5-bit register
    // are done at the wider of the two widths.
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(SAMPLE_BITS);

    t_swm_state r_state, n_state;

    logic [CFG_W-1:0]       r_len_cfg;
    logic [PTR_W-1:0]       r_ptr;
    logic [SAMPLE_BITS-1:0] r_win [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]  r_cand;
    logic [LEN_W-1:0]       r_rank;
    logic [CNT_W-1:0]       r_cnt;
    logic [SAMPLE_BITS-1:0] r_res;
    logic                   r_oval;
    logic [SAMPLE_BITS-1:0] r_med;

    logic [LEN_W-1:0]      len_eff;
    logic [CMP_W-1:0]      len_ext;
    logic [PTR_W-1:0]      slot;
    logic [PTR_W-1:0]      ptr_next;
    logic [MAX_WINDOW-1:0] top_bits;
    logic [MAX_WINDOW-1:0] zero_cand;
    logic [LEN_W-1:0]      zeros;
    logic                  pick_zero;
    logic                  res_bit;
    logic                  in_take;
    logic                  out_load;
    logic                  last_bit;

    // Effective window length: zero acts as one, large values saturate.
    always_comb begin
        len_ext = CMP_W'(r_len_cfg);
        if (len_ext == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_ext > CMP_W'(MAX_WINDOW)) begin
            len_eff = LEN_W'(MAX_WINDOW);
        end else begin
            len_eff = LEN_W'(r_len_cfg);
        end
    end

    // Slot to overwrite and the pointer after it, both wrapped to the length.
    always_comb begin
        if (LEN_W'(r_ptr) >= len_eff) begin
            slot = '0;
        end else begin
            slot = r_ptr;
        end
        if (LEN_W'(slot) + LEN_W'(1) >= len_eff) begin
            ptr_next = '0;
        end else begin
            ptr_next = slot + PTR_W'(1);
        end
    end

    // One selection step: count candidates whose current bit is zero. On the
    // sign bit the sense is inverted so that signed order is kept.
    always_comb begin
        zeros = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            top_bits[i] = r_win[i][SAMPLE_BITS-1] ^ (r_cnt == '0);
        end
        zero_cand = r_cand & ~top_bits;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            zeros = zeros + LEN_W'(zero_cand[i]);
        end
        pick_zero = (zeros > r_rank);
        res_bit   = (~pick_zero) ^ (r_cnt == '0);
        last_bit  = (r_cnt == CNT_W'(SAMPLE_BITS - 1));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_smp.valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_bit) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_oval || o_med.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        in_take  = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_take = i_smp.valid;
            end
            ST_DONE: begin
                out_load = !r_oval || o_med.ready;
            end
            default: begin
            end
        endcase
    end

    assign i_smp.ready  = (r_state == ST_IDLE);
    assign o_med.valid  = r_oval;
    assign o_med.median = r_med;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len_cfg <= RESET_LEN;
            r_ptr     <= '0;
            r_oval    <= 1'b0;
            r_cnt     <= '0;
            for (int i = 0; i < MAX_WINDOW; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_len_cfg <= i_cfg_wdata;
            end
            if (out_load) begin
                r_oval <= 1'b1;
            end else if (o_med.ready) begin
                r_oval <= 1'b0;
            end
            if (in_take) begin
                r_win[slot] <= i_smp.sample;
                r_ptr       <= ptr_next;
                r_cnt       <= '0;
            end else if (r_state == ST_RUN) begin
                // Rotate every slot; after SAMPLE_BITS steps each is back in place.
                for (int i = 0; i < MAX_WINDOW; i++) begin
                    r_win[i] <= {r_win[i][SAMPLE_BITS-2:0], r_win[i][SAMPLE_BITS-1]};
                end
                r_cnt <= last_bit ? '0 : r_cnt + CNT_W'(1);
            end
        end
    end

    // Selection datapath, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                r_cand[i] <= (LEN_W'(i) < len_eff);
            end
            r_rank <= len_eff >> 1;
        end else if (r_state == ST_RUN) begin
            if (pick_zero) begin
                r_cand <= zero_cand;
            end else begin
                r_cand <= r_cand & top_bits;
                r_rank <= r_rank - zeros;
            end
            r_res <= {r_res[SAMPLE_BITS-2:0], res_bit};
        end
        if (out_load) begin
            r_med <= r_res;
        end
    end

endmodule
